[rtl/core/stream_duplicate_filter_top_assert.svh]
// assertion macros for the duplicate filter
// expects clk and rst in the scope of use
`ifndef STREAM_DUPLICATE_FILTER_TOP_ASSERT_SVH
`define STREAM_DUPLICATE_FILTER_TOP_ASSERT_SVH

// condition holds on every edge out of reset
`define SDF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SDF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/sdf_pkg.sv]
// shared types and constants for the duplicate filter
// no dependencies
package sdf_pkg;

  localparam int VALUE_W          = 32;
  localparam int SEEN_DEPTH_DEF   = 64;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic               hit;
    logic               placed;
    logic               last;
  } tok_t;

endpackage

[rtl/core/sdf_cell.sv]
// one store cell of the duplicate filter chain
// depends on sdf_pkg
module sdf_cell #(
  parameter int DEPTH = sdf_pkg::SEEN_DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  sdf_pkg::tok_t                tok_i,
  output sdf_pkg::tok_t                tok_o
);
  import sdf_pkg::*;

  localparam int CW = $clog2(DEPTH+1);

  logic [VALUE_W-1:0] entry;
  logic               used;
  logic               match;
  logic               take;
  tok_t               tok_next;

  always_comb begin
    used              = CW'(IDX) < count;
    match             = used && (entry == tok_i.value);
    take              = tok_i.valid && !used && !tok_i.hit && !tok_i.placed;
    tok_next          = tok_i;
    tok_next.hit      = tok_i.hit | match;
    tok_next.placed   = tok_i.placed | take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_o.valid <= 1'b0;
    end else if (advance) begin
      tok_o.valid <= tok_next.valid;
    end
    if (advance) begin
      tok_o.value  <= tok_next.value;
      tok_o.hit    <= tok_next.hit;
      tok_o.placed <= tok_next.placed;
      tok_o.last   <= tok_next.last;
    end
    if (advance && take) begin
      entry <= tok_i.value;
    end
  end

endmodule

[rtl/core/stream_duplicate_filter_top.sv]
// top level of the duplicate filter: cell chain, fill count, output register
// depends on sdf_pkg, sdf_cell and stream_duplicate_filter_top_assert.svh
//
//   channel  handshake             payload
//   in       in_valid / in_ready   value, last_item
//   out      out_valid / out_ready value_out, keep, last_out, overflow
//
// a word walks the chain one cell per cycle; no new word is accepted until the
// previous word has left the last cell for the output register
// the result is registered in the output register as the word leaves the last cell
// the output register lets the next word enter while a result waits
// a stalled output holds the word in the last cell until taken
// reset empties the store at once; a word marked last empties it after its pass
module stream_duplicate_filter_top #(
  parameter int SEEN_DEPTH = sdf_pkg::SEEN_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [sdf_pkg::VALUE_W-1:0] value,
  input  logic                         last_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [sdf_pkg::VALUE_W-1:0] value_out,
  output logic                         keep,
  output logic                         last_out,
  output logic                         overflow
);
  import sdf_pkg::*;

  `include "stream_duplicate_filter_top_assert.svh"

  localparam int CW = $clog2(SEEN_DEPTH+1);

  tok_t              chain [0:SEEN_DEPTH];
  logic [SEEN_DEPTH-1:0] tok_valids;
  logic [CW-1:0]     count;
  logic              busy;
  logic              accept;
  logic              tail_move;
  logic              advance;

  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign tail_move = chain[SEEN_DEPTH].valid && (!out_valid || out_ready);
  assign advance   = !chain[SEEN_DEPTH].valid || tail_move;

  always_comb begin
    chain[0].valid  = accept;
    chain[0].value  = value;
    chain[0].hit    = 1'b0;
    chain[0].placed = 1'b0;
    chain[0].last   = last_item;
  end

  for (genvar i = 0; i < SEEN_DEPTH; i++) begin : g_cell
    sdf_cell #(
      .DEPTH (SEEN_DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .count   (count),
      .tok_i   (chain[i]),
      .tok_o   (chain[i+1])
    );
    assign tok_valids[i] = chain[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (tail_move) begin
        busy <= 1'b0;
      end
      if (tail_move) begin
        out_valid <= 1'b1;
        if (chain[SEEN_DEPTH].last) begin
          count <= '0;
        end else if (chain[SEEN_DEPTH].placed) begin
          count <= count + CW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_move) begin
      value_out <= chain[SEEN_DEPTH].value;
      keep      <= !chain[SEEN_DEPTH].hit;
      last_out  <= chain[SEEN_DEPTH].last;
      overflow  <= !chain[SEEN_DEPTH].hit && !chain[SEEN_DEPTH].placed;
    end
  end

  `SDF_ASSERT_ALWAYS(a_one_word, $onehot0(tok_valids), "more than one word in the chain")
  `SDF_ASSERT_ALWAYS(a_count_range, count <= CW'(SEEN_DEPTH), "fill count past store depth")
  `SDF_ASSERT_NEXT(a_busy_after_accept, accept, busy && !in_ready, "accepted word not tracked")
  `SDF_ASSERT_IMPL(a_ovf_keep, out_valid && overflow, keep, "overflow on a dropped word")

endmodule

[sim/tb.sv]
// testbench for stream_duplicate_filter_top: directed lists, then random lists and noise
// depends on sdf_pkg and the rtl top; a scoreboard class tracks the seen store per list
module tb;
  import sdf_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               keep;
    logic               last;
    logic               ovf;
  } verdict_t;

  class dedup_scoreboard;
    logic [VALUE_W-1:0] seen_vals [SEEN_DEPTH_DEF];
    int                 seen_cnt;
    verdict_t           due [$];
    int                 errors;
    int                 n_kept;
    int                 n_dropped;
    int                 n_ovf;

    function new();
      seen_cnt  = 0;
      errors    = 0;
      n_kept    = 0;
      n_dropped = 0;
      n_ovf     = 0;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function int pending_count();
      return due.size();
    endfunction

    function void note_word(logic [VALUE_W-1:0] v, logic l);
      verdict_t r;
      bit       hit;
      hit = 1'b0;
      for (int i = 0; i < seen_cnt; i++) begin
        if (seen_vals[i] == v) hit = 1'b1;
      end
      r.value = v;
      r.last  = l;
      r.keep  = !hit;
      r.ovf   = 1'b0;
      if (!hit) begin
        if (seen_cnt < SEEN_DEPTH_DEF) begin
          seen_vals[seen_cnt] = v;
          seen_cnt++;
        end else begin
          r.ovf = 1'b1;
        end
      end
      if (l) seen_cnt = 0;
      if (r.keep) n_kept++; else n_dropped++;
      if (r.ovf) n_ovf++;
      due.push_back(r);
    endfunction

    task check_word(logic [VALUE_W-1:0] v, logic k, logic l, logic o);
      verdict_t want;
      if (due.size() == 0) begin
        report($sformatf("result %0d with no word pending", $signed(v)));
        return;
      end
      want = due.pop_front();
      if (v !== want.value)
        report($sformatf("value_out %0d, wanted %0d", $signed(v), $signed(want.value)));
      if (k !== want.keep)
        report($sformatf("keep %b for %0d, wanted %b", k, $signed(want.value), want.keep));
      if (l !== want.last)
        report($sformatf("last_out %b for %0d, wanted %b", l, $signed(want.value), want.last));
      if (o !== want.ovf)
        report($sformatf("overflow %b for %0d, wanted %b", o, $signed(want.value), want.ovf));
    endtask
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] value     = '0;
  logic                      last_item = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] value_out;
  logic                      keep;
  logic                      last_out;
  logic                      overflow;

  dedup_scoreboard    sb;
  bit                 idle_on    = 1'b1;
  int                 stall_left = 0;
  int                 words_sent = 0;
  int                 lists_sent = 0;
  logic [VALUE_W-1:0] list_vals [$];

  stream_duplicate_filter_top #(
    .SEEN_DEPTH(SEEN_DEPTH_DEF)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .last_item (last_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_out (value_out),
    .keep      (keep),
    .last_out  (last_out),
    .overflow  (overflow)
  );

  always #5 clk = ~clk;

  // input word noted before the result check of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(value, last_item);
      if (out_valid && out_ready) sb.check_word(value_out, keep, last_out, overflow);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [VALUE_W-1:0] v, input logic l);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    value     <= v;
    last_item <= l;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_list();
    for (int i = 0; i < list_vals.size(); i++)
      send_word(list_vals[i], i == list_vals.size() - 1);
    lists_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  initial begin
    logic [VALUE_W-1:0] pool [$];
    int                 kind;
    int                 len;
    int                 fill;

    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // extremes, duplicates, duplicate on the last word, store cleared between lists
    list_vals = '{32'h8000_0000};
    send_list();
    list_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                  32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000};
    send_list();
    list_vals = '{32'h8000_0000};
    send_list();
    list_vals = '{32'h0000_0005, 32'h0000_0005, 32'h0000_0005};
    send_list();
    list_vals = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555};
    send_list();

    while (words_sent < 1900) begin
      if (words_sent >= 1750) idle_on = 1'b0;
      kind = $urandom_range(0, 99);
      if (lists_sent == 8 || kind < 3) drain_results();
      pool.delete();
      list_vals.delete();
      if (lists_sent == 10 || kind < 10) begin
        // fill the store to around full, then repeat stored and unstored values
        fill = $urandom_range(62, 72);
        for (int i = 0; i < fill; i++) pool.push_back($urandom);
        list_vals = pool;
        len = $urandom_range(2, 20);
        for (int i = 0; i < len; i++) list_vals.push_back(pool[$urandom_range(0, fill - 1)]);
        send_list();
      end else if (kind < 92) begin
        fill = $urandom_range(1, 12);
        for (int i = 0; i < fill; i++) pool.push_back(pick_value());
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) list_vals.push_back(pool[$urandom_range(0, fill - 1)]);
        send_list();
      end else begin
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++) send_word(pick_value(), $urandom_range(0, 3) == 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
    repeat (80) @(posedge clk);
    if (sb.pending_count() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_count()));

    $display("%0d words over %0d lists and noise runs", words_sent, lists_sent);
    $display("%0d first occurrences, %0d duplicates, %0d with store full",
             sb.n_kept, sb.n_dropped, sb.n_ovf);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout with %0d results pending", sb.pending_count());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sdf_pkg.sv
rtl/core/sdf_cell.sv
rtl/core/stream_duplicate_filter_top.sv
sim/tb.sv
